>>> src/bspa_pkg.sv
// Shared types and constants of the bitmap slot pool allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bspa_pkg;

  // Default pool size; the top level hands its parameter down from here.
  localparam int BSPA_POOL_SIZE = 64;

  // Field widths fixed by the interface.
  localparam int SLOT_W   = 6;
  localparam int AMOUNT_W = 7;
  localparam int STATUS_W = 2;

  // Depth of the command queue between front and back.
  localparam int QDEPTH   = 2;

  // Input action codes.
  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED = 2'd2;

  // Command kinds decided by the front.
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_ZERO    = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic [1:0]          kind;
    logic [AMOUNT_W-1:0] amount;
    logic [SLOT_W-1:0]   slot;
    logic                in_range;
  } cmd_t;

endpackage

>>> src/bitmap_slot_pool_allocator_unit.sv
// Top level of the bitmap slot pool allocator.
// Depends on bspa_pkg, bspa_front, bspa_cmd_queue and bspa_back.
`timescale 1ns / 1ps

// A first-fit allocator over a pool of POOL_SIZE slots, each with a busy bit.
// The input channel (in_valid/in_ready) carries one word per request: action
// selects allocate or release, amount is the number of slots wanted, and slot
// names the slot to free. The output channel (out_valid/out_ready) returns
// result words; last marks the final word of each request.
// An allocate returns one word per granted slot, lowest free index first;
// the last of them reports ok or not-enough. A zero count, or a request that
// finds the pool full, gives a single word without a slot. A release gives a
// single acknowledge word and frees the slot if it lies inside the pool.
// The front decodes each word into a command and parks it in a two-entry
// queue, so in_ready stays high until two commands are waiting. The back
// takes the queue head and writes one result per cycle into the output
// register while the receiver takes them. The first result is offered from
// the output register once its request has passed through the queue, and
// the back's first-fit search sets the throughput of one result per cycle.
// Reset frees every slot and empties the queue and the output register.
// When the receiver holds out_ready low, the current word stays put, the
// back stops and the queue fills, after which in_ready drops.

module bitmap_slot_pool_allocator_unit
  import bspa_pkg::*;
#(
  parameter int POOL_SIZE = BSPA_POOL_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                action,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic [SLOT_W-1:0]   slot,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   granted_slot,
  output logic                has_slot,
  output logic [STATUS_W-1:0] status,
  output logic                last
);

  cmd_t in_cmd;
  cmd_t head_cmd;
  logic queue_full;
  logic head_valid;
  logic pop;

  assign in_ready = !queue_full;

  bspa_front #(
    .POOL_SIZE(POOL_SIZE)
  ) u_front (
    .action(action),
    .amount(amount),
    .slot  (slot),
    .cmd   (in_cmd)
  );

  bspa_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_cmd  (in_cmd),
    .full      (queue_full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  bspa_back #(
    .POOL_SIZE(POOL_SIZE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .granted_slot(granted_slot),
    .has_slot    (has_slot),
    .status      (status),
    .last        (last)
  );

endmodule

>>> src/bspa_front.sv
// Front of the allocator: decodes an incoming word into a queued command.
// Depends on bspa_pkg.
`timescale 1ns / 1ps

module bspa_front
  import bspa_pkg::*;
#(
  parameter int POOL_SIZE = BSPA_POOL_SIZE
) (
  input  logic                action,
  input  logic [AMOUNT_W-1:0] amount,
  input  logic [SLOT_W-1:0]   slot,
  output cmd_t                cmd
);

  localparam logic [SLOT_W:0] POOL_LIMIT = (SLOT_W+1)'(POOL_SIZE);

  always_comb begin
    cmd.amount   = amount;
    cmd.slot     = slot;
    cmd.in_range = ({1'b0, slot} < POOL_LIMIT);
    if (action == ACT_RELEASE) begin
      cmd.kind = KIND_RELEASE;
    end else if (amount == '0) begin
      cmd.kind = KIND_ZERO;
    end else begin
      cmd.kind = KIND_ALLOC;
    end
  end

endmodule

>>> src/bspa_cmd_queue.sv
// Short command queue that lets the front and the back stall independently.
// Depends on bspa_pkg for the command type and depth.
`timescale 1ns / 1ps

module bspa_cmd_queue
  import bspa_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cmd_t             entries [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/bspa_back.sv
// Back of the allocator: owns the busy bitmap, runs the first-fit search and
// drives the output register one result per cycle unless the output is stalled. Depends on bspa_pkg.
`timescale 1ns / 1ps

module bspa_back
  import bspa_pkg::*;
#(
  parameter int POOL_SIZE = BSPA_POOL_SIZE
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                head_valid,
  input  cmd_t                head_cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   granted_slot,
  output logic                has_slot,
  output logic [STATUS_W-1:0] status,
  output logic                last
);

  logic [POOL_SIZE-1:0] busy;
  logic [POOL_SIZE-1:0] busy_next;
  logic [POOL_SIZE-1:0] free_mask;
  logic [POOL_SIZE-1:0] lo_bit;
  logic [POOL_SIZE-1:0] rel_mask;
  logic [SLOT_W-1:0]    lo_idx;
  logic                 any_free;
  logic                 more_free;
  logic [AMOUNT_W-1:0]  count;
  logic [AMOUNT_W-1:0]  count_next;
  logic [AMOUNT_W-1:0]  count_inc;
  logic                 final_grant;
  logic                 step;

  logic [SLOT_W-1:0]    res_slot;
  logic                 res_has;
  logic [STATUS_W-1:0]  res_status;
  logic                 res_last;

  // Lowest free slot isolated as a one-hot mask, then encoded.
  assign free_mask = ~busy;
  assign lo_bit    = free_mask & (~free_mask + POOL_SIZE'(1));
  assign any_free  = |free_mask;
  assign more_free = |(free_mask & ~lo_bit);

  always_comb begin
    lo_idx = '0;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (lo_bit[i]) begin
        lo_idx = lo_idx | SLOT_W'(i);
      end
    end
  end

  assign rel_mask    = head_cmd.in_range ? (POOL_SIZE'(1) << head_cmd.slot) : '0;
  assign count_inc   = count + AMOUNT_W'(1);
  assign final_grant = (count_inc == head_cmd.amount);
  assign step        = head_valid && (!out_valid || out_ready);
  assign pop         = step && res_last;

  always_comb begin
    res_slot   = '0;
    res_has    = 1'b0;
    res_status = ST_OK;
    res_last   = 1'b1;
    busy_next  = busy;
    count_next = count;
    case (head_cmd.kind)
      KIND_RELEASE: begin
        res_status = ST_RELEASED;
        busy_next  = busy & ~rel_mask;
      end
      KIND_ZERO: begin
        res_status = ST_OK;
      end
      KIND_ALLOC: begin
        if (!any_free) begin
          // Only reachable on the first step: an earlier grant would have
          // ended the request when it took the last free slot.
          res_status = ST_SHORT;
        end else begin
          res_slot   = lo_idx;
          res_has    = 1'b1;
          busy_next  = busy | lo_bit;
          res_last   = final_grant || !more_free;
          res_status = (res_last && !final_grant) ? ST_SHORT : ST_OK;
          count_next = count_inc;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
    if (res_last) begin
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else if (step) begin
      busy      <= busy_next;
      count     <= count_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      granted_slot <= res_slot;
      has_slot     <= res_has;
      status       <= res_status;
      last         <= res_last;
    end
  end

endmodule

>>> src/bspa_checker.sv
// Port-level checks of the allocator, bound to the top level.
// Depends on bspa_pkg and bitmap_slot_pool_allocator_unit.
`timescale 1ns / 1ps

module bspa_checker
  import bspa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [SLOT_W-1:0]   granted_slot,
  input logic                has_slot,
  input logic [STATUS_W-1:0] status,
  input logic                last
);

  // A stalled result word holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(granted_slot)
      && $stable(has_slot) && $stable(status) && $stable(last))
    else $error("result word changed while stalled");

  // A word without a grant carries slot zero.
  a_no_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_slot |-> granted_slot == '0)
    else $error("slot index set without a grant");

  // A release acknowledge is a single word without a slot.
  a_release_ack: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_RELEASED |-> last && !has_slot)
    else $error("malformed release acknowledge");

  // Only the final word of a request may report a final status; earlier
  // words are ok grants.
  a_mid_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> has_slot && status == ST_OK)
    else $error("non-final word is not a plain grant");

  // A word without a slot always closes its request.
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_slot |-> last)
    else $error("slotless word does not close its request");

endmodule

bind bitmap_slot_pool_allocator_unit bspa_checker u_bspa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .granted_slot(granted_slot),
  .has_slot    (has_slot),
  .status      (status),
  .last        (last)
);
